/* hdl/bcss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcss_pkg
// Shared sizes, codes and controller/datapath interface types for the
// bounded cover selection search.
// ----------------------------------------------------------------------------
package bcss_pkg;

    localparam int NumPos    = 16;
    localparam int NumEnt    = 32;
    localparam int MultW     = 8;
    localparam int BoundW    = 16;
    localparam int TotalW    = 17;
    localparam int PosIdxW   = 4;
    localparam int EntIdxW   = 5;
    localparam int PosCntW   = 5;
    localparam int EntCntW   = 6;
    localparam int RowW      = NumPos * MultW;

    // request kinds carried in the input tuser
    localparam logic [1:0] OP_LOAD_BOUND = 2'd0;
    localparam logic [1:0] OP_LOAD_MULT  = 2'd1;
    localparam logic [1:0] OP_FIRST      = 2'd2;
    localparam logic [1:0] OP_NEXT       = 2'd3;

    // configuration register indexes
    localparam logic CFG_POSITION_COUNT = 1'b0;
    localparam logic CFG_ENTRY_COUNT    = 1'b1;

    // datapath commands
    typedef enum logic [3:0] {
        C_NOP,
        C_LOAD_BOUND,
        C_LOAD_MULT,
        C_CLEAR,
        C_REM_ADDR,
        C_REM_STEP,
        C_FWD_ADDR,
        C_FWD_EVAL,
        C_BACK_ADDR,
        C_DROP,
        C_RESUME,
        C_FOUND,
        C_EXHAUST
    } t_cmd;

    // datapath status toward the controller
    typedef struct packed {
        logic rem_done;     // remainder pass has no entry left
        logic cover_fail;   // remaining entries cannot cover the positions
        logic scan_end;     // forward scan passed the last entry
        logic uncov_zero;   // every position in use is covered
        logic fits;         // current row keeps all totals in bounds
        logic rem_short;    // later entries miss an uncovered position
        logic chosen_zero;  // selection is empty
        logic out_full;     // result register still holds a beat
    } t_stat;

endpackage
`default_nettype wire

/* hdl/bcss_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcss_dp
// Search datapath: vector memory, bounds, per-position totals, remainder
// masks, selection, scan pointer and the result register.
// ----------------------------------------------------------------------------
module bcss_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bcss_pkg::t_cmd             i_cmd,
    input  wire logic [bcss_pkg::EntIdxW-1:0] i_ent,
    input  wire logic [bcss_pkg::PosIdxW-1:0] i_pos,
    input  wire logic [15:0]                i_val,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_index,
    input  wire logic [7:0]                 i_cfg_data,
    input  wire logic                       i_m_tready,
    output logic                            o_m_tvalid,
    output logic [31:0]                     o_m_tdata,
    output logic                            o_m_tuser,
    output bcss_pkg::t_stat                 o_stat
);

    logic [bcss_pkg::RowW-1:0]   r_mem [bcss_pkg::NumEnt];
    logic [bcss_pkg::RowW-1:0]   r_row;
    logic [bcss_pkg::BoundW-1:0] r_bound [bcss_pkg::NumPos];
    logic [bcss_pkg::TotalW-1:0] r_tot [bcss_pkg::NumPos];
    logic [bcss_pkg::NumPos-1:0] r_rem [bcss_pkg::NumEnt];
    logic [bcss_pkg::NumEnt-1:0] r_chosen;
    logic [bcss_pkg::EntCntW-1:0] r_scan;
    logic [bcss_pkg::NumPos-1:0] r_acc;
    logic [bcss_pkg::EntCntW-1:0] r_cnt;
    logic [bcss_pkg::EntIdxW-1:0] r_addr;
    logic [bcss_pkg::PosCntW-1:0] r_pos_cnt;
    logic [bcss_pkg::EntCntW-1:0] r_ent_cnt;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [31:0]                 r_out_mask;

    logic [bcss_pkg::PosCntW-1:0] np;
    logic [bcss_pkg::EntCntW-1:0] ne;
    logic [bcss_pkg::NumPos-1:0]  in_use;
    logic [bcss_pkg::NumPos-1:0]  uncov;
    logic [bcss_pkg::NumPos-1:0]  support;
    logic [bcss_pkg::NumPos-1:0]  rem_sel;
    logic                         fits;
    logic [bcss_pkg::EntIdxW-1:0] top_idx;
    logic [bcss_pkg::MultW-1:0]   mult [bcss_pkg::NumPos];

    // saturate the counts
    assign np = (r_pos_cnt > bcss_pkg::PosCntW'(bcss_pkg::NumPos))
              ? bcss_pkg::PosCntW'(bcss_pkg::NumPos) : r_pos_cnt;
    assign ne = (r_ent_cnt > bcss_pkg::EntCntW'(bcss_pkg::NumEnt))
              ? bcss_pkg::EntCntW'(bcss_pkg::NumEnt) : r_ent_cnt;
    assign rem_sel = r_rem[r_addr];

    // per-position lanes: fit test, coverage and support
    always_comb begin
        fits = 1'b1;
        for (int p = 0; p < bcss_pkg::NumPos; p++) begin
            mult[p]    = r_row[p*bcss_pkg::MultW +: bcss_pkg::MultW];
            in_use[p]  = bcss_pkg::PosCntW'(p) < np;
            uncov[p]   = in_use[p] && (r_tot[p] == '0);
            support[p] = in_use[p] && (mult[p] != '0);
            if (in_use[p] && (({1'b0, r_tot[p]} + 18'(mult[p])) > 18'(r_bound[p]))) begin
                fits = 1'b0;
            end
        end
    end

    // highest selected entry
    always_comb begin
        top_idx = '0;
        for (int k = 0; k < bcss_pkg::NumEnt; k++) begin
            if (r_chosen[k]) begin
                top_idx = bcss_pkg::EntIdxW'(k);
            end
        end
    end

    assign o_stat.rem_done    = (r_cnt == '0);
    assign o_stat.cover_fail  = |(uncov & ~r_acc);
    assign o_stat.scan_end    = (r_scan >= ne);
    assign o_stat.uncov_zero  = (uncov == '0);
    assign o_stat.fits        = fits;
    assign o_stat.rem_short   = |(uncov & ~rem_sel);
    assign o_stat.chosen_zero = (r_chosen == '0);
    assign o_stat.out_full    = r_out_valid;

    // memories and bounds: written by loads, row read each cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd == bcss_pkg::C_LOAD_MULT) begin
            r_mem[i_ent][i_pos*bcss_pkg::MultW +: bcss_pkg::MultW] <= i_val[bcss_pkg::MultW-1:0];
        end
        if (i_cmd == bcss_pkg::C_LOAD_BOUND) begin
            r_bound[i_pos] <= i_val[bcss_pkg::BoundW-1:0];
        end
        r_row <= r_mem[r_addr];
        if (i_cmd == bcss_pkg::C_FOUND) begin
            r_out_found <= 1'b1;
            r_out_mask  <= r_chosen;
        end else if (i_cmd == bcss_pkg::C_EXHAUST) begin
            r_out_found <= 1'b0;
            r_out_mask  <= '0;
        end
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < bcss_pkg::NumPos; p++) r_tot[p] <= '0;
            for (int e = 0; e < bcss_pkg::NumEnt; e++) r_rem[e] <= '0;
            r_chosen    <= '0;
            r_scan      <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_addr      <= '0;
            r_pos_cnt   <= bcss_pkg::PosCntW'(1);
            r_ent_cnt   <= bcss_pkg::EntCntW'(1);
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                if (i_cfg_index == bcss_pkg::CFG_POSITION_COUNT) begin
                    r_pos_cnt <= i_cfg_data[bcss_pkg::PosCntW-1:0];
                end else begin
                    r_ent_cnt <= i_cfg_data[bcss_pkg::EntCntW-1:0];
                end
            end
            // drain the result beat
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                bcss_pkg::C_CLEAR, bcss_pkg::C_EXHAUST: begin
                    for (int p = 0; p < bcss_pkg::NumPos; p++) r_tot[p] <= '0;
                    r_chosen <= '0;
                    r_scan   <= '0;
                    r_acc    <= '0;
                    r_cnt    <= ne;
                    if (i_cmd == bcss_pkg::C_EXHAUST) begin
                        r_out_valid <= 1'b1;
                    end
                end
                bcss_pkg::C_REM_ADDR: begin
                    r_addr <= bcss_pkg::EntIdxW'(r_cnt - 1'b1);
                end
                bcss_pkg::C_REM_STEP: begin
                    r_rem[r_addr] <= r_acc;
                    r_acc         <= r_acc | support;
                    r_cnt         <= r_cnt - 1'b1;
                end
                bcss_pkg::C_FWD_ADDR: begin
                    r_addr <= r_scan[bcss_pkg::EntIdxW-1:0];
                end
                bcss_pkg::C_FWD_EVAL: begin
                    // add the entry when it fits, skip it when the rest still cover
                    if (fits) begin
                        for (int p = 0; p < bcss_pkg::NumPos; p++) begin
                            if (in_use[p]) r_tot[p] <= r_tot[p] + bcss_pkg::TotalW'(mult[p]);
                        end
                        r_chosen[r_addr] <= 1'b1;
                    end
                    if (fits || !(|(uncov & ~rem_sel))) begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                bcss_pkg::C_BACK_ADDR: begin
                    r_addr <= top_idx;
                end
                bcss_pkg::C_DROP: begin
                    for (int p = 0; p < bcss_pkg::NumPos; p++) begin
                        if (in_use[p]) begin
                            r_tot[p] <= (bcss_pkg::TotalW'(mult[p]) > r_tot[p]) ? '0
                                      : r_tot[p] - bcss_pkg::TotalW'(mult[p]);
                        end
                    end
                    r_chosen[r_addr] <= 1'b0;
                end
                bcss_pkg::C_RESUME: begin
                    r_scan <= bcss_pkg::EntCntW'(r_addr) + 1'b1;
                end
                bcss_pkg::C_FOUND: begin
                    r_out_valid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_mask;
    assign o_m_tuser  = r_out_found;

endmodule
`default_nettype wire

/* hdl/bcss_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcss_ctrl
// Sequencer of the depth-first search: remainder pass, forward scan,
// backtracking and result hand-off.
// ----------------------------------------------------------------------------
module bcss_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_s_tvalid,
    input  wire logic [1:0]      i_op,
    input  wire bcss_pkg::t_stat i_stat,
    output logic                 o_s_tready,
    output bcss_pkg::t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_REM_A, S_REM_W, S_REM_S, S_COVER,
        S_FWD_A, S_FWD_W, S_FWD_E,
        S_BK_A, S_BK_W, S_BK_D, S_BK_C,
        S_FOUND, S_EXH
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;

    // next state and command
    always_comb begin
        n_state = r_state;
        o_cmd   = bcss_pkg::C_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && o_s_tready) begin
                    case (i_op)
                        bcss_pkg::OP_LOAD_BOUND: o_cmd = bcss_pkg::C_LOAD_BOUND;
                        bcss_pkg::OP_LOAD_MULT:  o_cmd = bcss_pkg::C_LOAD_MULT;
                        bcss_pkg::OP_FIRST: begin
                            o_cmd   = bcss_pkg::C_CLEAR;
                            n_state = S_REM_A;
                        end
                        default: begin
                            n_state = i_stat.chosen_zero ? S_EXH : S_BK_A;
                        end
                    endcase
                end
            end
            S_REM_A: begin
                if (i_stat.rem_done) begin
                    n_state = S_COVER;
                end else begin
                    o_cmd   = bcss_pkg::C_REM_ADDR;
                    n_state = S_REM_W;
                end
            end
            S_REM_W: n_state = S_REM_S;
            S_REM_S: begin
                o_cmd   = bcss_pkg::C_REM_STEP;
                n_state = S_REM_A;
            end
            S_COVER: n_state = i_stat.cover_fail ? S_EXH : S_FWD_A;
            S_FWD_A: begin
                if (i_stat.scan_end) begin
                    n_state = i_stat.uncov_zero ? S_FOUND : S_BK_A;
                end else begin
                    o_cmd   = bcss_pkg::C_FWD_ADDR;
                    n_state = S_FWD_W;
                end
            end
            S_FWD_W: n_state = S_FWD_E;
            S_FWD_E: begin
                o_cmd   = bcss_pkg::C_FWD_EVAL;
                n_state = (!i_stat.fits && i_stat.rem_short) ? S_BK_A : S_FWD_A;
            end
            S_BK_A: begin
                if (i_stat.chosen_zero) begin
                    n_state = S_EXH;
                end else begin
                    o_cmd   = bcss_pkg::C_BACK_ADDR;
                    n_state = S_BK_W;
                end
            end
            S_BK_W: n_state = S_BK_D;
            S_BK_D: begin
                o_cmd   = bcss_pkg::C_DROP;
                n_state = S_BK_C;
            end
            S_BK_C: begin
                if (!i_stat.rem_short) begin
                    o_cmd   = bcss_pkg::C_RESUME;
                    n_state = S_FWD_A;
                end else begin
                    n_state = S_BK_A;
                end
            end
            S_FOUND: begin
                if (!i_stat.out_full) begin
                    o_cmd   = bcss_pkg::C_FOUND;
                    n_state = S_IDLE;
                end
            end
            S_EXH: begin
                if (!i_stat.out_full) begin
                    o_cmd   = bcss_pkg::C_EXHAUST;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* hdl/bounded_cover_selection_search.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_cover_selection_search
// Depth-first enumerator of entry subsets that cover every position in use
// without exceeding the per-position bounds.
//
// Input beats: tuser is the request kind (load bound, load multiplicity,
// first selection, next selection); tdata carries entry_index, position_index
// and load_value. Loads are written as they are taken and return nothing.
// First and next requests return one beat: tuser = found, tdata = selection
// mask (zero when the search is exhausted). The time a request takes is set
// by the search: a first request makes a remainder pass over the entries
// (address, memory read, step per entry) and then a cover check, every
// forward step visits one row (address, memory read, evaluate) and every
// backward step one row (address, memory read, drop, check); the result is
// registered once the search ends. A next request starts backtracking at
// once; one on an empty selection goes straight to the exhausted result.
// One request is in work at a time; the input stalls until it completes.
// The result sits in an output register; a stalled receiver only holds the
// block when a second result is ready before the first is taken.
// Reset (synchronous, active low) clears selection, totals, remainder masks
// and counts (both 1); the multiplicity and bound tables are undefined until
// loaded. Configuration writes are taken every cycle out of reset.
// ----------------------------------------------------------------------------
module bounded_cover_selection_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [4:0] entry_index, [8:5] position_index,
                                          // [24:9] load_value, [31:25] zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] op
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [31:0] selection_mask
    output logic             o_m_tuser,   // [0] found
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    bcss_pkg::t_cmd  cmd;
    bcss_pkg::t_stat stat;

    assign o_cfg_ready = i_rst_n;

    bcss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    bcss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_ent       (i_s_tdata[4:0]),
        .i_pos       (i_s_tdata[8:5]),
        .i_val       (i_s_tdata[24:9]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_stat      (stat)
    );

endmodule
`default_nettype wire

/* test/bounded_cover_selection_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_cover_selection_search_tb
// Self-checking bench for the cover selection search. Load, first and next
// beats are driven from a queue with random gaps. Each accepted request is run
// through a local depth-first search model. Every result beat is checked
// against the oldest predicted selection. Position and entry counts change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module bounded_cover_selection_search_tb;
    import bcss_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  ent;
        logic [3:0]  pos;
        logic [15:0] val;
    } req_t;

    typedef struct {
        logic        found;
        logic [31:0] mask;
    } sel_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;
    wire         s_tready, m_tvalid, m_tuser, cfg_ready;
    wire  [31:0] m_tdata;

    bounded_cover_selection_search uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    req_t pending[$];
    sel_t selections_due[$];
    int   mismatches = 0;
    bit   calm = 1'b0;
    bit   in_hs = 1'b0;
    int   send_gap = 0;
    int   take_gap = 0;

    // search model state
    logic [7:0]  mult_tab [0:NumEnt*NumPos-1];
    logic [15:0] bound_tab [0:NumPos-1];
    logic [31:0] later_support [0:NumEnt-1];
    int          totals [0:NumPos-1];
    logic [31:0] uncov;
    logic [31:0] chosen;
    int          scan;
    int          pos_cnt = 1;
    int          ent_cnt = 1;

    function automatic int pick_gap();
        int r;
        r = $urandom % 100;
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int used_pos();
        return pos_cnt > NumPos ? NumPos : pos_cnt;
    endfunction

    function automatic void refresh_uncov();
        int p;
        uncov = '0;
        for (p = 0; p < used_pos(); p++)
            if (totals[p] == 0) uncov[p] = 1'b1;
    endfunction

    function automatic void clear_search();
        int p;
        for (p = 0; p < NumPos; p++) totals[p] = 0;
        chosen = '0;
        scan = 0;
        uncov = (used_pos() >= 32) ? '1 : ((32'd1 << used_pos()) - 1);
    endfunction

    // Apply one request to the model; first and next requests queue a selection.
    task automatic search_request(input req_t rq);
        int   ne, np, e, k, p;
        logic [31:0] acc;
        bit   fwd, dead, done, ok;
        sel_t r;
        if (rq.op == OP_LOAD_BOUND) begin
            bound_tab[rq.pos] = rq.val;
            return;
        end
        if (rq.op == OP_LOAD_MULT) begin
            mult_tab[rq.ent*NumPos + rq.pos] = rq.val[7:0];
            return;
        end
        ne = ent_cnt > NumEnt ? NumEnt : ent_cnt;
        np = used_pos();
        done = 1'b0;
        fwd = 1'b0;
        r.found = 1'b0;
        if (rq.op == OP_FIRST) begin
            clear_search();
            acc = '0;
            for (e = ne; e > 0; e--) begin
                later_support[e-1] = acc;
                for (p = 0; p < np; p++)
                    if (mult_tab[(e-1)*NumPos + p] != 0) acc[p] = 1'b1;
            end
            if ((uncov & ~acc) != 0) done = 1'b1;
            else fwd = 1'b1;
        end else if (chosen == 0) begin
            done = 1'b1;
        end
        while (!done) begin
            if (fwd) begin
                dead = 1'b0;
                while (scan < ne && !dead) begin
                    e = scan;
                    ok = 1'b1;
                    for (p = 0; p < np; p++)
                        if (totals[p] + mult_tab[e*NumPos + p] > bound_tab[p]) ok = 1'b0;
                    if (ok) begin
                        for (p = 0; p < np; p++) totals[p] += mult_tab[e*NumPos + p];
                        chosen[e] = 1'b1;
                        refresh_uncov();
                    end else if ((uncov & ~later_support[e]) != 0) begin
                        dead = 1'b1;
                    end
                    if (!dead) scan++;
                end
                if (!dead && uncov == 0) begin
                    r.found = 1'b1;
                    done = 1'b1;
                end
            end
            if (!done) begin
                // back off the highest chosen entry until the rest can still cover
                fwd = 1'b0;
                while (chosen != 0 && !fwd) begin
                    k = 31;
                    while (!chosen[k]) k--;
                    for (p = 0; p < np; p++)
                        totals[p] = (mult_tab[k*NumPos + p] > totals[p]) ? 0 :
                                    totals[p] - mult_tab[k*NumPos + p];
                    chosen[k] = 1'b0;
                    refresh_uncov();
                    if ((uncov & ~later_support[k]) == 0) begin
                        scan = k + 1;
                        fwd = 1'b1;
                    end
                end
                if (!fwd) done = 1'b1;
            end
        end
        if (r.found) begin
            r.mask = chosen;
        end else begin
            clear_search();
            r.mask = '0;
        end
        selections_due.push_back(r);
    endtask

    // Drive request beats at the falling edge; hold a beat until taken.
    always @(negedge i_clk) begin
        req_t rq;
        if (!s_tvalid || in_hs) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                rq = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= rq.op;
                s_tdata <= {7'd0, rq.val, rq.pos, rq.ent};
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        // stall the result side now and then
        if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= i_rst_n;
            if ($urandom % 4 == 0) take_gap <= pick_gap();
        end
    end

    // Sample both sides at the rising edge.
    always @(posedge i_clk) begin
        req_t rq;
        sel_t ex;
        in_hs <= s_tvalid && s_tready;
        if (s_tvalid && s_tready) begin
            rq.op = s_tuser;
            rq.ent = s_tdata[4:0];
            rq.pos = s_tdata[8:5];
            rq.val = s_tdata[24:9];
            search_request(rq);
        end
        if (m_tvalid && m_tready) begin
            if (selections_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: found %0b mask %h", m_tuser, m_tdata);
            end else begin
                ex = selections_due.pop_front();
                if (ex.found !== m_tuser || ex.mask !== m_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected found %0b mask %h, got %0b %h",
                                 ex.found, ex.mask, m_tuser, m_tdata);
                end
            end
        end
    end

    function automatic req_t make_req(input logic [1:0] op, input int ent, input int pos,
                                      input int val);
        req_t rq;
        rq.op = op;
        rq.ent = 5'(ent);
        rq.pos = 4'(pos);
        rq.val = 16'(val);
        return rq;
    endfunction

    function automatic req_t rand_load(input bit wide);
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom % 2) begin
            if ($urandom % 2) v[7:0] = 8'd0;
            return make_req(OP_LOAD_MULT, $urandom % 32, $urandom % 16, v);
        end
        if (wide) v[15] = 1'b1;
        else if ($urandom % 4 != 0) v = 16'($urandom_range(0, 1200));
        return make_req(OP_LOAD_BOUND, 0, $urandom % 16, v);
    endfunction

    // Wait until nothing is in flight, then let trailing loads settle.
    task automatic wait_idle();
        while (pending.size() > 0 || s_tvalid || selections_due.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        if (idx == CFG_POSITION_COUNT) pos_cnt = data[4:0];
        else ent_cnt = data[5:0];
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic fill_phase(input int budget, input bit wide);
        int p, n;
        for (p = 0; p < NumPos; p++)
            pending.push_back(make_req(OP_LOAD_BOUND, 0, p,
                wide ? (16'h8000 | $urandom) : $urandom_range(0, 1200)));
        while (budget > 0) begin
            if ($urandom % 10 < 7) begin
                // well-formed: first, then a run of nexts with a load now and then
                pending.push_back(make_req(OP_FIRST, $urandom, $urandom, $urandom));
                budget--;
                for (n = $urandom_range(0, wide ? 2 : 6); n > 0; n--) begin
                    if ($urandom % 5 == 0) begin
                        pending.push_back(rand_load(wide));
                        budget--;
                    end
                    pending.push_back(make_req(OP_NEXT, $urandom, $urandom, $urandom));
                    budget--;
                end
            end else if ($urandom % 4 == 0) begin
                pending.push_back(make_req(OP_NEXT, $urandom, $urandom, $urandom));
                budget--;
            end else begin
                pending.push_back(rand_load(wide));
                budget--;
            end
        end
    endtask

    initial begin
        logic [7:0] pc_set [0:9];
        logic [7:0] ec_set [0:9];
        int  ph, e, p, ue;
        logic [7:0] pc, ec;
        pc_set = '{8'd1, 8'd16, 8'd0, 8'd255, 8'd4, 8'd16, 8'd1, 8'd7, 8'd31, 8'd3};
        ec_set = '{8'd1, 8'd32, 8'd5, 8'd255, 8'd8, 8'd1, 8'd32, 8'd0, 8'd6, 8'd63};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        ent_cnt = 1;
        pos_cnt = 1;
        clear_search();
        uncov = '1;

        // next with nothing selected, straight out of reset
        pending.push_back(make_req(OP_NEXT, 0, 0, 0));
        // fill both tables so that no search reads an unwritten row
        for (p = 0; p < NumPos; p++)
            pending.push_back(make_req(OP_LOAD_BOUND, 0, p, $urandom_range(0, 1200)));
        for (e = 0; e < NumEnt; e++)
            for (p = 0; p < NumPos; p++)
                pending.push_back(make_req(OP_LOAD_MULT, e, p,
                    ($urandom % 2) ? $urandom : ($urandom & 16'hff00)));
        // directed: extremes, uncoverable basis, next after exhaustion
        pending.push_back(make_req(OP_LOAD_MULT, 0, 0, 16'h00ff));
        pending.push_back(make_req(OP_LOAD_BOUND, 0, 0, 16'hffff));
        pending.push_back(make_req(OP_FIRST, 31, 15, 16'hffff));
        pending.push_back(make_req(OP_NEXT, 0, 0, 0));
        pending.push_back(make_req(OP_NEXT, 0, 0, 0));
        pending.push_back(make_req(OP_LOAD_MULT, 0, 0, 16'hff00));
        pending.push_back(make_req(OP_FIRST, 0, 0, 0));
        pending.push_back(make_req(OP_NEXT, 0, 0, 0));
        pending.push_back(make_req(OP_LOAD_MULT, 0, 0, 16'd1));
        pending.push_back(make_req(OP_LOAD_BOUND, 0, 0, 16'd0));
        pending.push_back(make_req(OP_FIRST, 0, 0, 0));
        pending.push_back(make_req(OP_LOAD_BOUND, 0, 0, 16'd1));
        pending.push_back(make_req(OP_FIRST, 0, 0, 0));
        pending.push_back(make_req(OP_LOAD_MULT, 0, 0, 16'd2));
        pending.push_back(make_req(OP_NEXT, 0, 0, 0));
        pending.push_back(make_req(OP_LOAD_MULT, 0, 0, 16'd1));
        wait_idle();

        for (ph = 0; ph < 24; ph++) begin
            if (ph < 10) begin
                pc = pc_set[ph];
                ec = ec_set[ph];
            end else begin
                pc = ($urandom % 6 == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
                ec = ($urandom % 6 == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
            end
            write_reg(CFG_POSITION_COUNT, pc);
            write_reg(CFG_ENTRY_COUNT, ec);
            ue = ec[5:0] > NumEnt ? NumEnt : ec[5:0];
            calm = (ph % 4 == 3);
            fill_phase(40, ue > 10);
            wait_idle();
        end

        if (mismatches == 0 && selections_due.size() == 0) begin
            $display("bounded_cover_selection_search_tb OK");
        end else begin
            $display("bounded_cover_selection_search_tb NOT OK");
        end
        $finish;
    end

    // Hard stop for a hung handshake or runaway search.
    initial begin
        #1_000_000_000;
        $display("bounded_cover_selection_search_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bcss_pkg.sv
hdl/bcss_dp.sv
hdl/bcss_ctrl.sv
hdl/bounded_cover_selection_search.sv
test/bounded_cover_selection_search_tb.sv
